[rtl/core/wlgm_pkg.sv]
// window/level gray mapper: shared widths, register indexes, padding modes
// and the payload types that travel down the pipeline; no dependencies
`timescale 1ns / 1ps

package wlgm_pkg;

    localparam int PIX_W          = 16;
    localparam int PIXEL_BITS_DEF = 16;
    localparam int GRAY_W         = 8;
    localparam int CENTER_W       = 20;
    localparam int WIDTH_W        = 21;
    localparam int PAD_MODE_W     = 2;
    localparam int NUM_W          = 24;
    localparam int DEN_W          = WIDTH_W + 1;
    localparam int QUO_W          = GRAY_W;
    localparam int REM_W          = DEN_W + QUO_W;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 21;
    localparam int WIDTH_MIN      = 16;

    localparam logic [GRAY_W-1:0] GRAY_MAX = 8'd255;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_MODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_VALUE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_LIMIT = 3'd5;

    // padding modes, the reserved code acts as range
    localparam logic [PAD_MODE_W-1:0] PAD_NONE   = 2'd0;
    localparam logic [PAD_MODE_W-1:0] PAD_SINGLE = 2'd1;
    localparam logic [PAD_MODE_W-1:0] PAD_RANGE  = 2'd2;
    localparam logic [PAD_MODE_W-1:0] PAD_RSVD   = 2'd3;

    typedef struct packed {
        logic [CENTER_W-1:0]   window_center;
        logic [WIDTH_W-1:0]    window_width;
        logic                  invert_enable;
        logic [PAD_MODE_W-1:0] padding_mode;
        logic [PIX_W-1:0]      padding_value;
        logic [PIX_W-1:0]      padding_limit;
    } cfg_t;

    typedef struct packed {
        logic padded;
        logic sat_low;
        logic sat_high;
        logic invert;
    } flags_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
        flags_t           flags;
    } div_t;

endpackage

[rtl/core/wlgm_front.sv]
// window/level gray mapper front end: window offset, padding test, saturation
// test and scaling by 255 over two register stages; uses wlgm_pkg
`timescale 1ns / 1ps

module wlgm_front #(
    parameter int PIXEL_BITS = wlgm_pkg::PIXEL_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [wlgm_pkg::PIX_W-1:0] in_pixel,
    input  wlgm_pkg::cfg_t             cfg,
    output logic                       out_valid,
    input  logic                       out_ready,
    output wlgm_pkg::div_t             out_data
);

    localparam int PixW   = wlgm_pkg::PIX_W;
    localparam int NumW   = wlgm_pkg::NUM_W;
    localparam int DenW   = wlgm_pkg::DEN_W;
    localparam int RemW   = wlgm_pkg::REM_W;
    localparam int WidthW = wlgm_pkg::WIDTH_W;
    localparam int QuoW   = wlgm_pkg::QUO_W;

    logic                  a_vld_reg;
    logic [NumW-1:0]       a_num_reg;
    logic [NumW-1:0]       a_num_next;
    logic [DenW-1:0]       a_den_reg;
    logic [DenW-1:0]       a_den_next;
    wlgm_pkg::flags_t      a_flags_reg;
    wlgm_pkg::flags_t      a_flags_next;
    logic                  a_ready;

    logic                  b_vld_reg;
    wlgm_pkg::div_t        b_data_reg;
    wlgm_pkg::div_t        b_data_next;
    logic                  b_ready;

    logic signed [PIXEL_BITS-1:0] pix_nar;
    logic signed [PixW-1:0]       pix_s;
    logic signed [PixW-1:0]       pad_v;
    logic signed [PixW-1:0]       pad_l;
    logic signed [PixW-1:0]       pad_lo;
    logic signed [PixW-1:0]       pad_hi;
    logic [NumW-1:0]              pix_ext;
    logic [NumW-1:0]              ctr_ext;
    logic [WidthW-1:0]            w_eff;
    logic                         padded;
    logic                         sat_low;
    logic                         sat_high;

    assign b_ready  = !b_vld_reg || out_ready;
    assign a_ready  = !a_vld_reg || b_ready;
    assign in_ready = a_ready;

    // stage a: numerator (32*pix - 2*center + width) and padding test
    always_comb
    begin
        pix_nar = $signed(in_pixel[PIXEL_BITS-1:0]);
        pix_s   = PixW'(pix_nar);
        pad_v   = $signed(cfg.padding_value);
        pad_l   = $signed(cfg.padding_limit);
        pad_lo  = (pad_v < pad_l) ? pad_v : pad_l;
        pad_hi  = (pad_v < pad_l) ? pad_l : pad_v;
        pix_ext = NumW'(pix_s);
        ctr_ext = NumW'($signed(cfg.window_center));
        w_eff   = (cfg.window_width <= WidthW'(wlgm_pkg::WIDTH_MIN)) ?
                  WidthW'(wlgm_pkg::WIDTH_MIN) : cfg.window_width;

        unique case (cfg.padding_mode) inside
            wlgm_pkg::PAD_NONE:                     padded = 1'b0;
            wlgm_pkg::PAD_SINGLE:                   padded = (pix_s == pad_v);
            wlgm_pkg::PAD_RANGE, wlgm_pkg::PAD_RSVD:
                padded = (pix_s >= pad_lo) && (pix_s <= pad_hi);
            default:                                padded = 1'b0;
        endcase

        a_num_next = {pix_ext[NumW-6:0], 5'b0} - {ctr_ext[NumW-2:0], 1'b0}
                   + NumW'(w_eff);
        a_den_next = {w_eff, 1'b0};
        a_flags_next          = '0;
        a_flags_next.padded   = padded;
        a_flags_next.invert   = cfg.invert_enable;
    end

    // stage b: clamp tests and numerator times 255
    always_comb
    begin
        sat_low  = a_num_reg[NumW-1] || (a_num_reg == '0);
        sat_high = !sat_low && (a_num_reg[NumW-2:0] >= (NumW-1)'(a_den_reg));
        b_data_next                = '0;
        b_data_next.rem            = RemW'({a_num_reg[DenW-1:0], {QuoW{1'b0}}})
                                   - RemW'(a_num_reg[DenW-1:0]);
        b_data_next.den            = a_den_reg;
        b_data_next.flags          = a_flags_reg;
        b_data_next.flags.sat_low  = sat_low;
        b_data_next.flags.sat_high = sat_high;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_vld_reg <= in_valid;
            if (b_ready)
                b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_num_reg   <= a_num_next;
            a_den_reg   <= a_den_next;
            a_flags_reg <= a_flags_next;
        end
        if (b_ready && a_vld_reg)
            b_data_reg <= b_data_next;
    end

    assign out_valid = b_vld_reg;
    assign out_data  = b_data_reg;

    // scaled numerator stays below 256 times the denominator inside the window
    assert property (@(posedge clk) disable iff (!rst_n)
        b_vld_reg && !b_data_reg.flags.sat_low && !b_data_reg.flags.sat_high |->
            b_data_reg.rem < RemW'({b_data_reg.den, {QuoW{1'b0}}}))
        else $error("wlgm_front: scaled numerator out of range");

endmodule

[rtl/core/wlgm_div_stage.sv]
// window/level gray mapper: one restoring division stage, settles one
// quotient bit per register stage; uses wlgm_pkg
`timescale 1ns / 1ps

module wlgm_div_stage #(
    parameter int SHIFT = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  wlgm_pkg::div_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output wlgm_pkg::div_t out_data
);

    localparam int RemW = wlgm_pkg::REM_W;

    logic            vld_reg;
    wlgm_pkg::div_t  data_reg;
    wlgm_pkg::div_t  data_next;
    logic [RemW:0]   den_sh;
    logic [RemW:0]   trial;

    assign in_ready = !vld_reg || out_ready;

    always_comb
    begin
        den_sh    = (RemW + 1)'(in_data.den) << SHIFT;
        trial     = {1'b0, in_data.rem} - den_sh;
        data_next = in_data;
        if (!trial[RemW])
        begin
            data_next.rem        = trial[RemW-1:0];
            data_next.quo[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_ready)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    // partial remainder stays below the divisor at this bit weight
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg && !data_reg.flags.sat_low && !data_reg.flags.sat_high |->
            ({1'b0, data_reg.rem} < ((RemW + 1)'(data_reg.den) << SHIFT)))
        else $error("wlgm_div_stage: remainder not reduced");

endmodule

[rtl/core/window_level_gray_mapper.sv]
// window/level gray mapper top level: configuration registers, front end,
// eight division stages and the output stage; uses wlgm_pkg, wlgm_front,
// wlgm_div_stage
//
//   channel   dir   handshake                 payload
//   s_axis    in    s_axis_tvalid/tready      tdata[15:0] pixel_value
//   m_axis    out   m_axis_tvalid/tready      tdata[7:0]  gray_level
//   cfg       in    cfg_valid/cfg_ready       cfg_index, cfg_data
//
// one pixel per clock unless back-pressure on m_axis stalls the pipe; a pixel
// passes two front stages, eight division stages and one output stage
// each stage holds while its successor is full and stalled; empty stages
// keep filling, so input is taken while a result waits on m_axis
// cfg_ready is always high; reset clears the valid bits and loads the default configuration
`timescale 1ns / 1ps

module window_level_gray_mapper #(
    parameter int PIXEL_BITS = wlgm_pkg::PIXEL_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,  // [15:0] pixel_value
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,  // [7:0] gray_level
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wlgm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wlgm_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int QuoW  = wlgm_pkg::QUO_W;
    localparam int GrayW = wlgm_pkg::GRAY_W;

    wlgm_pkg::cfg_t  cfg_reg;
    wlgm_pkg::cfg_t  cfg_next;

    logic            div_vld   [QuoW+1];
    logic            div_rdy   [QuoW+1];
    wlgm_pkg::div_t  div_data  [QuoW+1];

    logic              out_vld_reg;
    logic [GrayW-1:0]  out_gray_reg;
    logic [GrayW-1:0]  out_gray_next;
    logic [GrayW-1:0]  gray_raw;
    logic              out_ready;
    wlgm_pkg::div_t    last;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                wlgm_pkg::REG_CENTER:
                    cfg_next.window_center = cfg_data[wlgm_pkg::CENTER_W-1:0];
                wlgm_pkg::REG_WIDTH:
                    cfg_next.window_width  = cfg_data[wlgm_pkg::WIDTH_W-1:0];
                wlgm_pkg::REG_INVERT:
                    cfg_next.invert_enable = cfg_data[0];
                wlgm_pkg::REG_PAD_MODE:
                    cfg_next.padding_mode  = cfg_data[wlgm_pkg::PAD_MODE_W-1:0];
                wlgm_pkg::REG_PAD_VALUE:
                    cfg_next.padding_value = cfg_data[wlgm_pkg::PIX_W-1:0];
                wlgm_pkg::REG_PAD_LIMIT:
                    cfg_next.padding_limit = cfg_data[wlgm_pkg::PIX_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{window_center: '0,
                         window_width:  wlgm_pkg::WIDTH_W'(wlgm_pkg::WIDTH_MIN),
                         invert_enable: 1'b0,
                         padding_mode:  wlgm_pkg::PAD_NONE,
                         padding_value: '0,
                         padding_limit: '0};
        end
        else
            cfg_reg <= cfg_next;
    end

    wlgm_front #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_pixel  (s_axis_tdata),
        .cfg       (cfg_reg),
        .out_valid (div_vld[0]),
        .out_ready (div_rdy[0]),
        .out_data  (div_data[0])
    );

    // quotient bits from msb down
    for (genvar i = 0; i < QuoW; i++)
    begin : g_div
        wlgm_div_stage #(
            .SHIFT (QuoW - 1 - i)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_vld[i]),
            .in_ready  (div_rdy[i]),
            .in_data   (div_data[i]),
            .out_valid (div_vld[i+1]),
            .out_ready (div_rdy[i+1]),
            .out_data  (div_data[i+1])
        );
    end

    // output stage: clamp, invert, padding
    assign last      = div_data[QuoW];
    assign out_ready = !out_vld_reg || m_axis_tready;
    assign div_rdy[QuoW] = out_ready;

    always_comb
    begin
        if (last.flags.sat_low)
            gray_raw = '0;
        else if (last.flags.sat_high)
            gray_raw = wlgm_pkg::GRAY_MAX;
        else
            gray_raw = last.quo;

        if (last.flags.padded)
            out_gray_next = '0;
        else if (last.flags.invert)
            out_gray_next = wlgm_pkg::GRAY_MAX - gray_raw;
        else
            out_gray_next = gray_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (out_ready)
            out_vld_reg <= div_vld[QuoW];
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && div_vld[QuoW])
            out_gray_reg <= out_gray_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_gray_reg;

    // an empty output stage lets the whole pipe advance
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_vld_reg |-> s_axis_tready)
        else $error("window_level_gray_mapper: input stalled with empty output");

endmodule

[bench/tb_window_level_gray_mapper.sv]
// testbench for window_level_gray_mapper: drives pixel transfers and config writes,
// predicts each gray level and checks the output stream against it in order
// depends on wlgm_pkg and the window_level_gray_mapper rtl
`timescale 1ns / 1ps

module tb_window_level_gray_mapper;

    localparam int LATENCY = 11;

    typedef enum int {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_SELDOM,
        READY_PERIODIC
    } sink_mode_t;

    typedef struct {
        logic [wlgm_pkg::PIX_W-1:0]  pixel;
        logic [wlgm_pkg::GRAY_W-1:0] gray;
    } gray_check_t;

    logic                            clk;
    logic                            rst_n          = 1'b0;
    logic                            s_axis_tvalid  = 1'b0;
    logic                            s_axis_tready;
    logic [15:0]                     s_axis_tdata   = '0;  // [15:0] pixel_value
    logic                            m_axis_tvalid;
    logic                            m_axis_tready  = 1'b0;
    logic [7:0]                      m_axis_tdata;         // [7:0] gray_level
    logic                            cfg_valid      = 1'b0;
    logic                            cfg_ready;
    logic [wlgm_pkg::CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [wlgm_pkg::CFG_DATA_W-1:0] cfg_data       = '0;

    // predictor copy of the register file, reset values
    logic [wlgm_pkg::CENTER_W-1:0]   center_q    = '0;
    logic [wlgm_pkg::WIDTH_W-1:0]    width_q     = wlgm_pkg::WIDTH_W'(16);
    logic                            invert_q    = 1'b0;
    logic [wlgm_pkg::PAD_MODE_W-1:0] pad_mode_q  = wlgm_pkg::PAD_NONE;
    logic [wlgm_pkg::PIX_W-1:0]      pad_value_q = '0;
    logic [wlgm_pkg::PIX_W-1:0]      pad_limit_q = '0;

    logic [wlgm_pkg::PIX_W-1:0] pixels_pending[$];
    gray_check_t      gray_expected[$];
    gray_check_t      oldest;
    int               pixels_issued   = 0;
    int               pixels_accepted = 0;
    int               mismatches      = 0;
    int               burst_left      = 0;
    int               gap_left        = 0;
    int               stall_left      = 0;
    int               cycle_count     = 0;
    sink_mode_t       sink_mode       = READY_ALWAYS;
    int               random_sent;

    window_level_gray_mapper dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [wlgm_pkg::GRAY_W-1:0] predict_gray(
        input logic [wlgm_pkg::PIX_W-1:0] raw);
        longint pix, ctr, wid, num, den, pv, pl, lo, hi;
        logic   padded;
        logic [wlgm_pkg::GRAY_W-1:0] g;
        pix = longint'($signed(raw));
        ctr = longint'($signed(center_q));
        wid = longint'(width_q);
        pv  = longint'($signed(pad_value_q));
        pl  = longint'($signed(pad_limit_q));
        lo  = (pv < pl) ? pv : pl;
        hi  = (pv < pl) ? pl : pv;
        padded = 1'b0;
        if (pad_mode_q == wlgm_pkg::PAD_SINGLE)
            padded = (pix == pv);
        else if (pad_mode_q == wlgm_pkg::PAD_RANGE || pad_mode_q == wlgm_pkg::PAD_RSVD)
            padded = (pix >= lo && pix <= hi);
        if (padded)
            return '0;
        if (wid <= wlgm_pkg::WIDTH_MIN)
            wid = wlgm_pkg::WIDTH_MIN;
        // half-width offset folded in by working at five fraction bits
        num = pix * 32 - 2 * ctr + wid;
        den = 2 * wid;
        if (num <= 0)
            g = '0;
        else if (num >= den)
            g = wlgm_pkg::GRAY_MAX;
        else
            g = wlgm_pkg::GRAY_W'((num * 255) / den);
        if (invert_q)
            g = wlgm_pkg::GRAY_MAX - g;
        return g;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic queue_pixel(input int value);
        pixels_pending.push_back(wlgm_pkg::PIX_W'(value));
        pixels_issued++;
    endtask

    task automatic write_reg(input logic [wlgm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wlgm_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pixels_accepted < pixels_issued || gray_expected.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic random_phase(input int count);
        logic [wlgm_pkg::CENTER_W-1:0]   ctr;
        logic [wlgm_pkg::WIDTH_W-1:0]    wid;
        logic                            inv;
        logic [wlgm_pkg::PAD_MODE_W-1:0] mode;
        logic [wlgm_pkg::PIX_W-1:0]      pv, pl;
        int                              ctr_pix, wid_pix, off;
        ctr = wlgm_pkg::CENTER_W'($urandom());
        case ($urandom_range(0, 5))
            0: wid = wlgm_pkg::WIDTH_W'($urandom_range(0, 16));
            1: wid = wlgm_pkg::WIDTH_W'($urandom_range(17, 255));
            2: wid = wlgm_pkg::WIDTH_W'($urandom_range(256, 16383));
            3: wid = wlgm_pkg::WIDTH_W'($urandom_range(16384, 1048576));
            4: wid = wlgm_pkg::WIDTH_W'(1048576);
            default: wid = wlgm_pkg::WIDTH_W'($urandom());
        endcase
        inv  = 1'($urandom());
        mode = wlgm_pkg::PAD_MODE_W'($urandom_range(0, 3));
        pv   = wlgm_pkg::PIX_W'($urandom());
        pl   = ($urandom_range(0, 1) != 0) ?
               wlgm_pkg::PIX_W'(int'(pv) + $urandom_range(0, 200) - 100) :
               wlgm_pkg::PIX_W'($urandom());
        write_reg(wlgm_pkg::REG_CENTER, {1'($urandom()), ctr});
        write_reg(wlgm_pkg::REG_WIDTH, wid);
        write_reg(wlgm_pkg::REG_INVERT,
                  (wlgm_pkg::CFG_DATA_W'($urandom()) & ~wlgm_pkg::CFG_DATA_W'(1))
                  | wlgm_pkg::CFG_DATA_W'(inv));
        write_reg(wlgm_pkg::REG_PAD_MODE, {19'($urandom()), mode});
        write_reg(wlgm_pkg::REG_PAD_VALUE, {5'($urandom()), pv});
        write_reg(wlgm_pkg::REG_PAD_LIMIT, {5'($urandom()), pl});
        if ($urandom_range(0, 3) == 0)
            write_reg(wlgm_pkg::CFG_IDX_W'($urandom_range(
                          int'(wlgm_pkg::REG_PAD_LIMIT) + 1, 7)),
                      wlgm_pkg::CFG_DATA_W'($urandom()));
        ctr_pix = int'($signed(ctr)) >>> 4;
        wid_pix = int'(wid >> 4) + 1;
        repeat (count)
        begin
            case ($urandom_range(0, 9))
                0, 1: queue_pixel(int'($urandom_range(0, 65535)));
                2: queue_pixel(int'(pv) + int'($urandom_range(0, 4)) - 2);
                3: queue_pixel(int'(pl) + int'($urandom_range(0, 4)) - 2);
                default:
                begin
                    off = int'($urandom_range(0, 2 * wid_pix)) - wid_pix;
                    queue_pixel(ctr_pix + off);
                end
            endcase
        end
        drain();
    endtask

    // sender: bursts of transfers separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pixels_pending.size() != 0)
            begin
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 48);
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pixels_pending.pop_front();
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver: back-pressure pattern switches at random among four modes
    always @(posedge clk)
    begin
        cycle_count++;
        if (stall_left == 0)
        begin
            sink_mode  = sink_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 300);
        end
        else
            stall_left--;
        case (sink_mode)
            READY_ALWAYS:   m_axis_tready <= 1'b1;
            READY_MOSTLY:   m_axis_tready <= ($urandom_range(0, 3) != 0);
            READY_SELDOM:   m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:        m_axis_tready <= ((cycle_count % 7) < 3);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    wlgm_pkg::REG_CENTER:
                        center_q    = cfg_data[wlgm_pkg::CENTER_W-1:0];
                    wlgm_pkg::REG_WIDTH:
                        width_q     = cfg_data[wlgm_pkg::WIDTH_W-1:0];
                    wlgm_pkg::REG_INVERT:
                        invert_q    = cfg_data[0];
                    wlgm_pkg::REG_PAD_MODE:
                        pad_mode_q  = cfg_data[wlgm_pkg::PAD_MODE_W-1:0];
                    wlgm_pkg::REG_PAD_VALUE:
                        pad_value_q = cfg_data[wlgm_pkg::PIX_W-1:0];
                    wlgm_pkg::REG_PAD_LIMIT:
                        pad_limit_q = cfg_data[wlgm_pkg::PIX_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                gray_expected.push_back('{pixel: s_axis_tdata, gray: predict_gray(s_axis_tdata)});
                pixels_accepted++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (gray_expected.size() == 0)
                    report_mismatch($sformatf("unexpected transfer, gray %0d", m_axis_tdata));
                else
                begin
                    oldest = gray_expected.pop_front();
                    if (m_axis_tdata !== oldest.gray)
                        report_mismatch($sformatf("pixel %0d: gray_level %0d, predicted %0d",
                                                  $signed(oldest.pixel), m_axis_tdata,
                                                  oldest.gray));
                end
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: unit width centered at zero
        queue_pixel(-32768);
        queue_pixel(32767);
        queue_pixel(0);
        queue_pixel(-1);
        queue_pixel(1);
        drain();

        // window from 0 to 200, edges on both sides
        write_reg(wlgm_pkg::REG_CENTER, 21'd1600);
        write_reg(wlgm_pkg::REG_WIDTH, 21'd3200);
        queue_pixel(0);
        queue_pixel(100);
        queue_pixel(199);
        queue_pixel(200);
        queue_pixel(-32768);
        queue_pixel(32767);
        drain();

        // single padding value with inversion
        write_reg(wlgm_pkg::REG_INVERT, 21'd1);
        write_reg(wlgm_pkg::REG_PAD_MODE, wlgm_pkg::CFG_DATA_W'(wlgm_pkg::PAD_SINGLE));
        write_reg(wlgm_pkg::REG_PAD_VALUE, wlgm_pkg::CFG_DATA_W'(16'hFFFB));
        queue_pixel(-5);
        queue_pixel(-4);
        queue_pixel(-32768);
        drain();

        // range with swapped ends
        write_reg(wlgm_pkg::REG_INVERT, 21'd0);
        write_reg(wlgm_pkg::REG_PAD_MODE, wlgm_pkg::CFG_DATA_W'(wlgm_pkg::PAD_RANGE));
        write_reg(wlgm_pkg::REG_PAD_VALUE, 21'd100);
        write_reg(wlgm_pkg::REG_PAD_LIMIT, wlgm_pkg::CFG_DATA_W'(16'hFF9C));
        queue_pixel(-100);
        queue_pixel(100);
        queue_pixel(101);
        queue_pixel(-101);
        drain();

        // reserved padding mode, most negative center, widest nominal window
        write_reg(wlgm_pkg::REG_PAD_MODE, wlgm_pkg::CFG_DATA_W'(wlgm_pkg::PAD_RSVD));
        write_reg(wlgm_pkg::REG_PAD_VALUE, 21'd32767);
        write_reg(wlgm_pkg::REG_PAD_LIMIT, 21'd30000);
        write_reg(wlgm_pkg::REG_CENTER, 21'h180000);
        write_reg(wlgm_pkg::REG_WIDTH, 21'd1048576);
        write_reg(wlgm_pkg::REG_INVERT, 21'h1FFFFF);
        for (int i = int'(wlgm_pkg::REG_PAD_LIMIT) + 1; i < 8; i++)
            write_reg(wlgm_pkg::CFG_IDX_W'(i), 21'h1FFFFF);
        queue_pixel(32767);
        queue_pixel(29999);
        queue_pixel(-32768);
        drain();

        // most positive center, all-ones width, no padding
        write_reg(wlgm_pkg::REG_CENTER, 21'h07FFFF);
        write_reg(wlgm_pkg::REG_WIDTH, 21'h1FFFFF);
        write_reg(wlgm_pkg::REG_INVERT, 21'd0);
        write_reg(wlgm_pkg::REG_PAD_MODE, wlgm_pkg::CFG_DATA_W'(wlgm_pkg::PAD_NONE));
        queue_pixel(0);
        queue_pixel(-32768);
        queue_pixel(32767);
        queue_pixel(12345);
        drain();

        random_sent = 0;
        while (random_sent < 1200)
        begin
            int n;
            n = $urandom_range(40, 80);
            random_phase(n);
            random_sent += n;
        end

        drain();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #(10_000_000);
        $display("simulation failed");
        $finish;
    end

endmodule
